/* sv/rledec_pkg.sv */
package rledec_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WHITE_THR   = 2'd0;
    localparam logic [1:0] CFG_BLACK_THR   = 2'd1;
    localparam logic [1:0] CFG_INITIAL_THR = 2'd2;
    localparam logic [1:0] CFG_HYST_FRAMES = 2'd3;

    localparam logic [12:0] WHITE_THR_RESET   = 13'd2970;
    localparam logic [12:0] BLACK_THR_RESET   = 13'd2150;
    localparam logic [12:0] INITIAL_THR_RESET = 13'd2560;
    localparam logic [3:0]  HYST_RESET        = 4'd4;

    localparam logic [12:0] ZB_MAX     = 13'h1FFF;
    localparam logic [3:0]  STREAK_MAX = 4'hF;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_END     = 2'd2
    } t_status;

    typedef enum logic {
        CMD_RUN = 1'b0,
        CMD_END = 1'b1
    } t_command;

    function automatic logic [3:0] zeros_in_byte(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, ~b[i]};
        end
        return n;
    endfunction

    function automatic logic [3:0] streak_inc(input logic [3:0] s);
        return (s < STREAK_MAX) ? s + 4'd1 : STREAK_MAX;
    endfunction

endpackage

/* sv/rle_frame_decoder_border_hysteresis.sv */
// Run-length frame decoder with border-color hysteresis.
// Input channel (i_valid / o_ready) carries one word per run pair or end-of-stream
// command. Output channel (o_valid / i_ready) returns exactly one run descriptor
// per input word: start offset, clipped length, byte, status, frame completion
// with its zero-bit total, and the border color after this word.
// A word moves on to the result register when that register is empty or being taken.
// Throughput: one word per cycle while the receiver takes results; the frame
// position, zero-bit total and hysteresis state are updated on the edge that
// loads the result register, so the next word sees them at once.
// The per-word path is one 8x4 multiply (count times zero bits in the byte),
// a 14-bit add with saturation and the threshold compares.
// Reset (synchronous, active low) clears the frame position, the zero-bit total,
// the color decision and both streak counters, empties both registers and
// loads the default thresholds. Configuration writes take effect at once and
// are expected only while the block is idle.
// When the receiver stalls the result register holds; the input register still
// takes one more word, after which o_ready drops until the result is taken.
module rle_frame_decoder_border_hysteresis
    import rledec_pkg::*;
#(
    parameter int FRAME_BYTES = 640
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // input words
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_run_count,
    input  logic [7:0]  i_run_value,
    // result words
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_run_start,
    output logic [7:0]  o_run_length,
    output logic [7:0]  o_pixel_byte,
    output logic [1:0]  o_status,
    output logic        o_frame_done,
    output logic [12:0] o_frame_zero_bits,
    output logic        o_border_valid,
    output logic        o_border_white
);

    localparam logic [10:0] FRAME_LEN = 11'(FRAME_BYTES);

    // configuration registers
    logic [12:0] r_white_thr, r_black_thr, r_initial_thr;
    logic [3:0]  r_hyst;

    // input register
    logic       r_in_valid;
    t_command   r_cmd;
    logic [7:0] r_count, r_value;

    // decoder state
    logic [9:0]  r_pos, n_pos;
    logic [12:0] r_total, n_total;
    logic        r_known, n_known;
    logic        r_white, n_white;
    logic [3:0]  r_wstreak, n_wstreak;
    logic [3:0]  r_bstreak, n_bstreak;

    // result register
    logic        r_out_valid;
    logic [9:0]  r_start;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_pixel, n_pixel;
    t_status     r_status, n_status;
    logic        r_done, n_done;
    logic [12:0] r_zb, n_zb;

    logic        adv;
    logic [10:0] space, pos_sum;
    logic        overflow;
    logic [11:0] prod;
    logic [13:0] total_sum;
    logic [12:0] total_sat;
    logic [3:0]  w_inc, b_inc;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_thr   <= WHITE_THR_RESET;
            r_black_thr   <= BLACK_THR_RESET;
            r_initial_thr <= INITIAL_THR_RESET;
            r_hyst        <= HYST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WHITE_THR:   r_white_thr   <= i_cfg_data;
                CFG_BLACK_THR:   r_black_thr   <= i_cfg_data;
                CFG_INITIAL_THR: r_initial_thr <= i_cfg_data;
                CFG_HYST_FRAMES: r_hyst        <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd   <= t_command'(i_command);
            r_count <= i_run_count;
            r_value <= i_run_value;
        end
    end

    always_comb begin
        space     = FRAME_LEN - {1'b0, r_pos};
        pos_sum   = {1'b0, r_pos} + {3'd0, r_count};
        overflow  = {3'd0, r_count} > space;
        prod      = r_count * zeros_in_byte(r_value);
        total_sum = {1'b0, r_total} + {2'd0, prod};
        total_sat = total_sum[13] ? ZB_MAX : total_sum[12:0];
        w_inc     = streak_inc(r_wstreak);
        b_inc     = streak_inc(r_bstreak);

        n_pos     = r_pos;
        n_total   = r_total;
        n_known   = r_known;
        n_white   = r_white;
        n_wstreak = r_wstreak;
        n_bstreak = r_bstreak;
        n_length  = 8'd0;
        n_pixel   = 8'd0;
        n_status  = ST_OK;
        n_done    = 1'b0;
        n_zb      = 13'd0;

        if (r_cmd == CMD_END) begin
            n_status = ST_END;
            n_pos    = 10'd0;
            n_total  = 13'd0;
        end else if (overflow) begin
            // corrupt run: drop the partial frame
            n_pixel  = r_value;
            n_length = space[7:0];
            n_status = ST_CORRUPT;
            n_pos    = 10'd0;
            n_total  = 13'd0;
        end else begin
            n_pixel  = r_value;
            n_length = r_count;
            n_pos    = pos_sum[9:0];
            n_total  = total_sat;
            if (pos_sum >= FRAME_LEN) begin
                n_done  = 1'b1;
                n_zb    = total_sat;
                n_pos   = 10'd0;
                n_total = 13'd0;
                if (!r_known) begin
                    n_white = total_sat >= r_initial_thr;
                    n_known = 1'b1;
                end else if (!r_white) begin
                    if (total_sat >= r_white_thr) begin
                        n_wstreak = w_inc;
                        n_bstreak = 4'd0;
                        if (w_inc >= r_hyst) begin
                            n_white   = 1'b1;
                            n_wstreak = 4'd0;
                        end
                    end else if (total_sat <= r_black_thr) begin
                        n_bstreak = b_inc;
                        n_wstreak = 4'd0;
                    end else begin
                        n_wstreak = 4'd0;
                        n_bstreak = 4'd0;
                    end
                end else begin
                    if (total_sat <= r_black_thr) begin
                        n_bstreak = b_inc;
                        n_wstreak = 4'd0;
                        if (b_inc >= r_hyst) begin
                            n_white   = 1'b0;
                            n_bstreak = 4'd0;
                        end
                    end else if (total_sat >= r_white_thr) begin
                        n_wstreak = w_inc;
                        n_bstreak = 4'd0;
                    end else begin
                        n_wstreak = 4'd0;
                        n_bstreak = 4'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 10'd0;
            r_total     <= 13'd0;
            r_known     <= 1'b0;
            r_white     <= 1'b0;
            r_wstreak   <= 4'd0;
            r_bstreak   <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_pos     <= n_pos;
                r_total   <= n_total;
                r_known   <= n_known;
                r_white   <= n_white;
                r_wstreak <= n_wstreak;
                r_bstreak <= n_bstreak;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_start  <= r_pos;
            r_length <= n_length;
            r_pixel  <= n_pixel;
            r_status <= n_status;
            r_done   <= n_done;
            r_zb     <= n_zb;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_run_start       = r_start;
    assign o_run_length      = r_length;
    assign o_pixel_byte      = r_pixel;
    assign o_status          = r_status;
    assign o_frame_done      = r_done;
    assign o_frame_zero_bits = r_zb;
    assign o_border_valid    = r_known;
    assign o_border_white    = r_white;

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < FRAME_LEN)
        else $error("frame position past end of frame");

    a_done_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> !o_frame_done)
        else $error("frame completed on a corrupt or end-of-stream word");

    a_zb_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |-> (o_frame_zero_bits == 13'd0))
        else $error("zero-bit total shown without frame completion");

    a_white_needs_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_white |-> r_known)
        else $error("border white before a color was decided");

    a_state_held_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(adv) && $past(i_rst_n) |-> $stable(r_pos) && $stable(r_total))
        else $error("frame state changed without a word advancing");

endmodule
